// ===== rtl/svenc_pkg.sv =====
package svenc_pkg;

    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned CAP_W     = 32;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [63:0] ONE_MAX   = 64'd240;
    localparam logic [63:0] TWO_MAX   = 64'd2287;
    localparam logic [63:0] THREE_MAX = 64'd67823;
    localparam logic [11:0] TWO_BIAS  = 12'd240;
    localparam logic [16:0] THREE_BIAS = 17'd2288;
    localparam logic [7:0]  TWO_HDR   = 8'd241;
    localparam logic [7:0]  THREE_HDR = 8'd249;
    localparam logic [7:0]  LONG_HDR_BASE = 8'd246;

    typedef struct packed {
        logic              refuse;
        logic [7:0]        hdr;
        logic [LEN_W-1:0]  tail;
        logic [VALUE_W-1:0] payload;
    } t_desc;

    typedef struct packed {
        logic  push;
        t_desc desc;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/svenc_front.sv =====
module svenc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [svenc_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_is_signed,
    input  logic                         i_cfg_wr_en,
    input  logic [svenc_pkg::CAP_W-1:0]  i_cfg_wr_data,
    input  svenc_pkg::t_qstat            i_qstat,
    output svenc_pkg::t_push             o_push
);

    logic                          r_valid;
    logic [svenc_pkg::VALUE_W-1:0] r_value;
    logic                          r_is_signed;
    logic [svenc_pkg::CAP_W-1:0]   r_cap;
    logic [svenc_pkg::CAP_W-1:0]   r_used;
    logic [svenc_pkg::CAP_W-1:0]   n_used;

    logic [svenc_pkg::VALUE_W-1:0] u;
    logic [svenc_pkg::LEN_W-1:0]   len;
    logic [11:0]                   d2;
    logic [16:0]                   d3;
    logic [svenc_pkg::CAP_W-1:0]   left;
    logic                          refuse;
    logic                          push;
    svenc_pkg::t_desc              desc;

    assign push    = r_valid && !i_qstat.full;
    assign o_ready = !r_valid || !i_qstat.full;

    always_comb begin
        if (r_is_signed) begin
            u = {r_value[62:0], 1'b0} ^ {svenc_pkg::VALUE_W{r_value[63]}};
        end else begin
            u = r_value;
        end
        d2 = u[11:0] - svenc_pkg::TWO_BIAS;
        d3 = u[16:0] - svenc_pkg::THREE_BIAS;

        if (u <= svenc_pkg::ONE_MAX) begin
            len = 4'd1;
        end else if (u <= svenc_pkg::TWO_MAX) begin
            len = 4'd2;
        end else if (u <= svenc_pkg::THREE_MAX) begin
            len = 4'd3;
        end else if (u[63:24] == 40'd0) begin
            len = 4'd4;
        end else if (u[63:32] == 32'd0) begin
            len = 4'd5;
        end else if (u[63:40] == 24'd0) begin
            len = 4'd6;
        end else if (u[63:48] == 16'd0) begin
            len = 4'd7;
        end else if (u[63:56] == 8'd0) begin
            len = 4'd8;
        end else begin
            len = 4'd9;
        end

        left   = (r_cap >= r_used) ? (r_cap - r_used) : '0;
        refuse = left < {{(svenc_pkg::CAP_W-svenc_pkg::LEN_W){1'b0}}, len};

        desc.refuse  = refuse;
        desc.tail    = len - 4'd1;
        desc.payload = u;
        case (len)
            4'd1: begin
                desc.hdr = u[7:0];
            end
            4'd2: begin
                desc.hdr     = svenc_pkg::TWO_HDR + {5'd0, d2[10:8]};
                desc.payload = {52'd0, d2};
            end
            4'd3: begin
                desc.hdr     = svenc_pkg::THREE_HDR;
                desc.payload = {47'd0, d3};
            end
            default: begin
                desc.hdr = svenc_pkg::LONG_HDR_BASE + {4'd0, len};
            end
        endcase
        if (refuse) begin
            desc.hdr  = 8'd0;
            desc.tail = '0;
        end

        n_used = r_used;
        if (push && !refuse) begin
            n_used = r_used + {{(svenc_pkg::CAP_W-svenc_pkg::LEN_W){1'b0}}, len};
        end
    end

    assign o_push.push = push;
    assign o_push.desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cap   <= '0;
            r_used  <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
            end else if (push) begin
                r_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_value     <= i_value;
            r_is_signed <= i_is_signed;
        end
    end

endmodule

// ===== rtl/svenc_queue.sv =====
module svenc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  svenc_pkg::t_push  i_push,
    input  logic              i_pop,
    output svenc_pkg::t_qstat o_qstat,
    output svenc_pkg::t_desc  o_desc
);

    svenc_pkg::t_desc                r_mem [svenc_pkg::Q_DEPTH];
    logic [svenc_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [svenc_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [svenc_pkg::Q_CNT_W-1:0]   r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_qstat.full  = (r_count == svenc_pkg::Q_CNT_W'(svenc_pkg::Q_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign do_push = i_push.push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

endmodule

// ===== rtl/svenc_back.sv =====
module svenc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  svenc_pkg::t_qstat i_qstat,
    input  svenc_pkg::t_desc  i_desc,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_last,
    output logic              o_accepted
);

    logic                            r_valid;
    logic [7:0]                      r_byte;
    logic                            r_last;
    logic                            r_accepted;
    logic                            r_busy;
    logic [svenc_pkg::LEN_W-1:0]     r_rem;
    logic [svenc_pkg::VALUE_W-1:0]   r_payload;
    logic                            load;
    logic [2:0]                      sel;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_busy && !i_qstat.empty;
    assign sel   = 3'(r_rem - 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_rem   <= '0;
        end else if (load) begin
            if (r_busy) begin
                r_valid <= 1'b1;
                r_rem   <= r_rem - 4'd1;
                r_busy  <= (r_rem != 4'd1);
            end else if (!i_qstat.empty) begin
                r_valid <= 1'b1;
                r_rem   <= i_desc.tail;
                r_busy  <= (i_desc.tail != '0);
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_busy) begin
                r_byte     <= r_payload[{sel, 3'b000} +: 8];
                r_last     <= (r_rem == 4'd1);
                r_accepted <= 1'b1;
            end else if (!i_qstat.empty) begin
                r_byte     <= i_desc.hdr;
                r_last     <= (i_desc.tail == '0);
                r_accepted <= !i_desc.refuse;
                r_payload  <= i_desc.payload;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;
    assign o_accepted = r_accepted;

endmodule

// ===== rtl/sqlite4_varint_encoder.sv =====
// SQLite4-style varint encoder with a byte budget. Each request carries a 64-bit value
// (optionally zigzag-mapped) and yields 1 to 9 output bytes, most significant first, with
// o_last on the final byte, or a single refusal (byte 0, o_accepted low) if the code does
// not fit in buffer_capacity minus the bytes already taken. The front stage registers a
// request, classifies it and books its space; a four-entry descriptor queue feeds the back
// stage, which emits one byte per cycle while i_ready is high, so a request of length L
// occupies the output for L bytes (a refusal for one) and back-to-back requests stream
// without gaps. The first byte passes the front request register, a queue entry and the
// output byte register on its way out. Write the capacity only while the block is idle.
module sqlite4_varint_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_value,
    input  logic        i_is_signed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_accepted,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    svenc_pkg::t_push  push;
    svenc_pkg::t_qstat qstat;
    svenc_pkg::t_desc  desc;
    logic              pop;

    svenc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_is_signed   (i_is_signed),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_qstat       (qstat),
        .o_push        (push)
    );

    svenc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_desc  (desc)
    );

    svenc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (qstat),
        .i_desc     (desc),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .o_accepted (o_accepted)
    );

`ifndef SYNTHESIS
    a_refusal_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_last && o_out_byte == 8'd0))
        else $error("refusal not a single zero byte");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push |-> !qstat.full)
        else $error("descriptor pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("descriptor popped from empty queue");
`endif

endmodule

// ===== tb/tb_sqlite4_varint_encoder.sv =====
`timescale 1ns / 1ps

module tb_sqlite4_varint_encoder;

    localparam int unsigned DIR_ROWS       = 26;
    localparam int unsigned PHASE_REQS     = 31;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    localparam logic [63:0] ONE_BYTE_MAX   = 64'd240;
    localparam logic [63:0] TWO_BYTE_MAX   = 64'd2287;
    localparam logic [63:0] THREE_BYTE_MAX = 64'd67823;
    localparam logic [63:0] TWO_BYTE_BIAS  = 64'd240;
    localparam logic [63:0] THREE_BYTE_BIAS = 64'd2288;
    localparam logic [7:0]  HDR_TWO_BASE   = 8'd241;
    localparam logic [7:0]  HDR_THREE      = 8'd249;
    localparam int unsigned HDR_LONG_BASE  = 247;

    typedef enum logic [1:0] {CAP_KEEP, CAP_FULL, CAP_ROOM2, CAP_ZERO} cap_step_e;
    typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_PATTERN} rx_mode_e;

    typedef struct packed {
        cap_step_e   step;
        logic [63:0] value;
        logic        sgn;
        logic        typed;
        logic [3:0]  nbytes;
        logic [71:0] code;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       accepted;
    } enc_byte_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_value;
    logic        i_is_signed;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_accepted;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    logic        drv_typed;
    logic [3:0]  drv_len;
    logic [71:0] drv_code;

    logic [31:0] cap_q;
    logic [31:0] used_q;
    logic [31:0] room;
    logic [71:0] pr_code;
    int unsigned pr_len;
    enc_byte_t   pending_bytes[$];
    enc_byte_t   head;
    int unsigned err_cnt = 0;
    int unsigned idle_cycles = 0;

    int unsigned burst_left = 0;
    bit          gaps_on = 1'b1;
    rx_mode_e    rx_mode = RX_CHOPPY;
    bit          hold_off_req = 1'b0;
    logic [15:0] stall_pat = 16'b1101_1110_0111_0101;

    sqlite4_varint_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_is_signed   (i_is_signed),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .o_accepted    (o_accepted),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // code right-justified in the result, most significant byte first
    function automatic int unsigned varint_code(input logic [63:0] raw, input logic sgn,
                                                output logic [71:0] code);
        logic [63:0] u;
        logic [63:0] d;
        int unsigned tail;
        u = sgn ? ((raw << 1) ^ {64{raw[63]}}) : raw;
        code = '0;
        if (u <= ONE_BYTE_MAX) begin
            code[7:0] = u[7:0];
            return 1;
        end
        if (u <= TWO_BYTE_MAX) begin
            d = u - TWO_BYTE_BIAS;
            code[15:0] = {d[15:8] + HDR_TWO_BASE, d[7:0]};
            return 2;
        end
        if (u <= THREE_BYTE_MAX) begin
            d = u - THREE_BYTE_BIAS;
            code[23:0] = {HDR_THREE, d[15:0]};
            return 3;
        end
        if (u < 64'h100_0000) tail = 3;
        else if (u < 64'h1_0000_0000) tail = 4;
        else if (u < 64'h100_0000_0000) tail = 5;
        else if (u < 64'h1_0000_0000_0000) tail = 6;
        else if (u < 64'h100_0000_0000_0000) tail = 7;
        else tail = 8;
        code[63:0] = (tail == 8) ? u : (u & ((64'd1 << (8 * tail)) - 64'd1));
        code[8 * tail +: 8] = 8'(HDR_LONG_BASE + tail);
        return tail + 1;
    endfunction

    function automatic dir_row_t dir_row(input int unsigned idx);
        case (idx)
            0:  return '{CAP_KEEP,  64'd0,                  1'b0, 1'b1, 4'd0, 72'h0};
            1:  return '{CAP_FULL,  64'd0,                  1'b0, 1'b1, 4'd1, 72'h00};
            2:  return '{CAP_KEEP,  64'd240,                1'b0, 1'b1, 4'd1, 72'hF0};
            3:  return '{CAP_KEEP,  64'd241,                1'b0, 1'b1, 4'd2, 72'hF101};
            4:  return '{CAP_KEEP,  64'd2287,               1'b0, 1'b1, 4'd2, 72'hF8FF};
            5:  return '{CAP_KEEP,  64'd2288,               1'b0, 1'b1, 4'd3, 72'hF90000};
            6:  return '{CAP_KEEP,  64'd67823,              1'b0, 1'b1, 4'd3, 72'hF9FFFF};
            7:  return '{CAP_KEEP,  64'd67824,              1'b0, 1'b1, 4'd4, 72'hFA0108F0};
            8:  return '{CAP_KEEP,  64'hFF_FFFF,            1'b0, 1'b1, 4'd4, 72'hFAFFFFFF};
            9:  return '{CAP_KEEP,  64'h100_0000,           1'b0, 1'b1, 4'd5, 72'hFB01000000};
            10: return '{CAP_KEEP,  64'hFFFF_FFFF,          1'b0, 1'b1, 4'd5, 72'hFBFFFFFFFF};
            11: return '{CAP_KEEP,  64'h1_0000_0000,        1'b0, 1'b1, 4'd6,
                         72'hFC_01_0000_0000};
            12: return '{CAP_KEEP,  64'h100_0000_0000,      1'b0, 1'b1, 4'd7,
                         72'hFD_01_0000_0000_00};
            13: return '{CAP_KEEP,  64'h1_0000_0000_0000,   1'b0, 1'b1, 4'd8,
                         72'hFE_01_0000_0000_0000};
            14: return '{CAP_KEEP,  64'h100_0000_0000_0000, 1'b0, 1'b1, 4'd9,
                         72'hFF_01_0000_0000_0000_00};
            15: return '{CAP_KEEP,  '1,                     1'b0, 1'b1, 4'd9, '1};
            16: return '{CAP_KEEP,  64'd0,                  1'b1, 1'b1, 4'd1, 72'h00};
            17: return '{CAP_KEEP,  '1,                     1'b1, 1'b1, 4'd1, 72'h01};
            18: return '{CAP_KEEP,  64'd1,                  1'b1, 1'b1, 4'd1, 72'h02};
            19: return '{CAP_KEEP,  64'h8000_0000_0000_0000, 1'b1, 1'b1, 4'd9, '1};
            20: return '{CAP_KEEP,  64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 4'd9,
                         72'hFF_FFFF_FFFF_FFFF_FFFE};
            21: return '{CAP_KEEP,  64'hFFFF_FFFF_FFFF_FF87, 1'b1, 1'b1, 4'd2, 72'hF101};
            // two bytes of room: three-byte code refused, two-byte fits, then none left
            22: return '{CAP_ROOM2, 64'd2288,               1'b0, 1'b0, 4'd0, 72'h0};
            23: return '{CAP_KEEP,  64'd241,                1'b0, 1'b0, 4'd0, 72'h0};
            24: return '{CAP_KEEP,  64'd5,                  1'b0, 1'b0, 4'd0, 72'h0};
            // capacity below use
            default: return '{CAP_ZERO, 64'd0,             1'b0, 1'b1, 4'd0, 72'h0};
        endcase
    endfunction

    function automatic logic [63:0] pick_code_value(input int unsigned nbytes);
        logic [63:0] r;
        logic [63:0] lo;
        case (nbytes)
            1: return 64'($urandom_range(0, 240));
            2: return 64'($urandom_range(241, 2287));
            3: return 64'($urandom_range(2288, 67823));
            default: begin
                r = {$urandom, $urandom};
                if (nbytes != 9)
                    r &= (64'd1 << (8 * (nbytes - 1))) - 64'd1;
                lo = (nbytes == 4) ? 64'd67824 : (64'd1 << (8 * (nbytes - 2)));
                if (r < lo)
                    r |= (nbytes == 4) ? (64'd1 << 23) : lo;
                return r;
            end
        endcase
    endfunction

    // prediction and checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cap_q = '0;
            used_q = '0;
            pending_bytes.delete();
        end else begin
            if (i_valid && o_ready) begin
                pr_len = varint_code(i_value, i_is_signed, pr_code);
                room = (cap_q >= used_q) ? cap_q - used_q : '0;
                if (drv_typed) begin
                    if (drv_len == 0)
                        pending_bytes.push_back('{8'd0, 1'b1, 1'b0});
                    for (int k = 0; k < drv_len; k++)
                        pending_bytes.push_back('{drv_code[8 * (drv_len - 1 - k) +: 8],
                                                  k == drv_len - 1, 1'b1});
                end else if (room < pr_len) begin
                    pending_bytes.push_back('{8'd0, 1'b1, 1'b0});
                end else begin
                    for (int k = 0; k < pr_len; k++)
                        pending_bytes.push_back('{pr_code[8 * (pr_len - 1 - k) +: 8],
                                                  k == pr_len - 1, 1'b1});
                end
                if (room >= pr_len)
                    used_q = used_q + pr_len;
            end
            if (o_valid && i_ready) begin
                if (pending_bytes.size() == 0) begin
                    $error("unexpected byte %02h (last %b, accepted %b)",
                           o_out_byte, o_last, o_accepted);
                    err_cnt++;
                end else begin
                    head = pending_bytes.pop_front();
                    if (o_out_byte !== head.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", head.out_byte, o_out_byte);
                        err_cnt++;
                    end
                    if (o_last !== head.last) begin
                        $error("last: expected %b, got %b", head.last, o_last);
                        err_cnt++;
                    end
                    if (o_accepted !== head.accepted) begin
                        $error("accepted: expected %b, got %b", head.accepted, o_accepted);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_wr_en)
                cap_q = i_cfg_wr_data;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("tb_sqlite4_varint_encoder: FAIL");
                $finish;
            end
        end
    end

    // output side
    initial begin
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   i_ready = 1'b1;
                    RX_CHOPPY: i_ready = ($urandom_range(0, 3) != 0);
                    default: begin
                        i_ready = stall_pat[0];
                        stall_pat = {stall_pat[0], stall_pat[15:1]};
                    end
                endcase
            end
        end
    end

    task automatic send_req(input logic [63:0] v, input logic sgn, input logic typed,
                            input logic [3:0] tlen, input logic [71:0] tcode);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_value = v;
        i_is_signed = sgn;
        drv_typed = typed;
        drv_len = tlen;
        drv_code = tcode;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random_req();
        logic [63:0] u;
        logic        sgn;
        sgn = $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0)
            u = {$urandom, $urandom};
        else
            u = pick_code_value($urandom_range(1, 9));
        // undo the zigzag so signed requests land in the chosen length too
        send_req(sgn ? ((u >> 1) ^ {64{u[0]}}) : u, sgn, 1'b0, 4'd0, 72'h0);
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [31:0] c);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = c;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    initial begin
        dir_row_t row;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        i_is_signed = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        drv_typed = 1'b0;
        drv_len = '0;
        drv_code = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = dir_row(r);
            if (row.step != CAP_KEEP) begin
                go_idle();
                case (row.step)
                    CAP_FULL:  write_capacity('1);
                    CAP_ROOM2: write_capacity(used_q + 32'd2);
                    default:   write_capacity('0);
                endcase
            end
            send_req(row.value, row.sgn, row.typed, row.nbytes, row.code);
        end

        for (int p = 0; p < 6; p++) begin
            go_idle();
            case (p)
                0: begin
                    write_capacity('1);
                    rx_mode = RX_OPEN;
                    gaps_on = 1'b0;
                end
                1: begin
                    rx_mode = RX_CHOPPY;
                    gaps_on = 1'b1;
                    hold_off_req = 1'b1;
                end
                2: begin
                    write_capacity(used_q + $urandom_range(20, 120));
                    rx_mode = RX_PATTERN;
                end
                3: begin
                    write_capacity(used_q + $urandom_range(0, 8));
                    rx_mode = RX_CHOPPY;
                end
                4: begin
                    write_capacity($urandom);
                    rx_mode = RX_PATTERN;
                end
                default: begin
                    write_capacity(used_q + 32'd300);
                    rx_mode = RX_CHOPPY;
                    hold_off_req = 1'b1;
                end
            endcase
            repeat (PHASE_REQS) send_random_req();
        end

        go_idle();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb_sqlite4_varint_encoder: PASS");
        else
            $display("tb_sqlite4_varint_encoder: FAIL");
        $finish;
    end

endmodule

// ===== sqlite4_varint_encoder.f =====
rtl/svenc_pkg.sv
rtl/svenc_front.sv
rtl/svenc_queue.sv
rtl/svenc_back.sv
rtl/sqlite4_varint_encoder.sv
tb/tb_sqlite4_varint_encoder.sv
